### hdl/dfs_pkg.sv
package dfs_pkg;

	localparam int COORD_W   = 32;
	localparam int EDGE_W    = COORD_W + 1;
	localparam int OPND_W    = EDGE_W + 1;
	localparam int PROD_W    = 2 * OPND_W;
	localparam int NRM_W     = 2 * EDGE_W + 1;
	localparam int SPLIT     = EDGE_W;
	localparam int DOT_W     = NRM_W + EDGE_W + 4;
	localparam int SDIST_W   = 31;
	localparam int QUO_W     = 31;
	localparam int FRAC_BITS = 16;
	localparam int BARY_TOL  = 7;
	localparam int BARY_W    = NRM_W + FRAC_BITS + 3;
	localparam int NUM_STEPS = 16;
	localparam int STEP_W    = 5;
	localparam int CNT_W     = 5;

	// accumulate destinations of the shared multiplier
	localparam logic [2:0] DST_N0 = 3'd0;
	localparam logic [2:0] DST_N1 = 3'd1;
	localparam logic [2:0] DST_N2 = 3'd2;
	localparam logic [2:0] DST_U  = 3'd3;
	localparam logic [2:0] DST_V  = 3'd4;
	localparam logic [2:0] DST_D  = 3'd5;

	// register indexes
	localparam logic [1:0] REG_RAY_X = 2'd0;
	localparam logic [1:0] REG_RAY_Y = 2'd1;
	localparam logic [1:0] REG_RAY_Z = 2'd2;
	localparam logic [1:0] REG_SDIST = 2'd3;

	localparam logic [SDIST_W-1:0] SDIST_RESET = SDIST_W'(268435456);

	typedef struct packed {
		logic       vld;
		logic [2:0] dest;
		logic       clr;
		logic       sub;
		logic       hi;
	} mul_ctl_t;

endpackage

### hdl/dfs_ifs.sv
interface dfs_tri_if import dfs_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] vertex_a_x;
	logic [COORD_W-1:0] vertex_a_y;
	logic [COORD_W-1:0] vertex_a_z;
	logic [COORD_W-1:0] vertex_b_x;
	logic [COORD_W-1:0] vertex_b_y;
	logic [COORD_W-1:0] vertex_b_z;
	logic [COORD_W-1:0] vertex_c_x;
	logic [COORD_W-1:0] vertex_c_y;
	logic [COORD_W-1:0] vertex_c_z;
	logic               last_triangle;

	modport source (output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
		vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, last_triangle, input ready);
	modport sink (input valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
		vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, last_triangle, output ready);
endinterface

interface dfs_res_if import dfs_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] floor_height;
	logic               hit_found;

	modport source (output valid, floor_height, hit_found, input ready);
	modport sink (input valid, floor_height, hit_found, output ready);
endinterface

### hdl/dfs_mul.sv
module dfs_mul import dfs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic signed [OPND_W-1:0] op_a,
	input  logic signed [OPND_W-1:0] op_b,
	input  mul_ctl_t                 ctl,
	output logic signed [PROD_W-1:0] prod_s1,
	output mul_ctl_t                 ctl_s1
);

	// product register, control travels alongside
	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

endmodule

### hdl/downward_ray_floor_search.sv
// channel   dir  payload                                   accepted when
// tri_in    in   vertex_{a,b,c}_{x,y,z}, last_triangle     valid && ready
// res_out   out  floor_height, hit_found                   valid && ready
// wr_*      in   wr_index, wr_data                         wr_en
//
// from accept to the next accept, one triangle passes the accepting idle state,
// 16 issues of the shared 34x34 multiplier plus a drain, a check state, the
// restoring divider for the drop, and a finish state.
// a triangle rejected at the check skips the divider.
// tri_in.ready is high only while idle.
// reset clears the state, the best height and the output register.
// a last triangle waits in the finish cycle while an earlier result is unread.
module downward_ray_floor_search import dfs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	dfs_tri_if.sink            tri_in,
	dfs_res_if.source          res_out,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [COORD_W-1:0] wr_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	// configuration
	logic signed [COORD_W-1:0] ray_x_q, ray_y_q, ray_z_q;
	logic [SDIST_W-1:0]        sdist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray_x_q <= '0;
			ray_y_q <= '0;
			ray_z_q <= '0;
			sdist_q <= SDIST_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_RAY_X: ray_x_q <= wr_data;
				REG_RAY_Y: ray_y_q <= wr_data;
				REG_RAY_Z: ray_z_q <= wr_data;
				REG_SDIST: sdist_q <= wr_data[SDIST_W-1:0];
				default:   ;
			endcase
		end
	end

	// control
	logic [2:0]        st_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              rej_q;
	logic              seen_q;
	logic              out_vld_q;
	logic              accept;

	assign tri_in.ready = (st_q == ST_IDLE);
	assign accept       = tri_in.valid && tri_in.ready;

	// per-item operands: edges and ray offset, 33 bits each
	logic signed [EDGE_W-1:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
	logic signed [EDGE_W-1:0] wx_q, wy_q, wz_q;
	logic                     last_q;

	function automatic logic signed [EDGE_W-1:0] diff(input logic [COORD_W-1:0] p,
		input logic [COORD_W-1:0] q);
		return {p[COORD_W-1], p} - {q[COORD_W-1], q};
	endfunction

	always_ff @(posedge clk) begin
		if (accept) begin
			e1x_q  <= diff(tri_in.vertex_b_x, tri_in.vertex_a_x);
			e1y_q  <= diff(tri_in.vertex_b_y, tri_in.vertex_a_y);
			e1z_q  <= diff(tri_in.vertex_b_z, tri_in.vertex_a_z);
			e2x_q  <= diff(tri_in.vertex_c_x, tri_in.vertex_a_x);
			e2y_q  <= diff(tri_in.vertex_c_y, tri_in.vertex_a_y);
			e2z_q  <= diff(tri_in.vertex_c_z, tri_in.vertex_a_z);
			wx_q   <= diff(ray_x_q, tri_in.vertex_a_x);
			wy_q   <= diff(ray_y_q, tri_in.vertex_a_y);
			wz_q   <= diff(ray_z_q, tri_in.vertex_a_z);
			last_q <= tri_in.last_triangle;
		end
	end

	// accumulators fed by the multiplier
	logic signed [NRM_W-1:0] n0_q, n1_q, n2_q, u_q, v_q;
	logic signed [DOT_W-1:0] d_q;

	function automatic logic signed [OPND_W-1:0] ext(input logic signed [EDGE_W-1:0] x);
		return {x[EDGE_W-1], x};
	endfunction

	function automatic logic signed [OPND_W-1:0] lo(input logic signed [NRM_W-1:0] x);
		return {1'b0, x[SPLIT-1:0]};
	endfunction

	function automatic logic signed [OPND_W-1:0] hi(input logic signed [NRM_W-1:0] x);
		return x[NRM_W-1:SPLIT];
	endfunction

	// operand schedule: normal, barycentric crosses, then the plane dot product
	logic signed [OPND_W-1:0] op_a, op_b;
	mul_ctl_t                 ctl;

	always_comb begin
		op_a = '0;
		op_b = '0;
		ctl  = '0;
		ctl.vld = (st_q == ST_MUL) && (step_q < STEP_W'(NUM_STEPS));
		case (step_q)
			5'd0: begin op_a = ext(e1z_q); op_b = ext(e2x_q); ctl.dest = DST_N1; ctl.clr = 1'b1; end
			5'd1: begin op_a = ext(e1x_q); op_b = ext(e2z_q); ctl.dest = DST_N1; ctl.sub = 1'b1; end
			5'd2: begin op_a = ext(e1y_q); op_b = ext(e2z_q); ctl.dest = DST_N0; ctl.clr = 1'b1; end
			5'd3: begin op_a = ext(e1z_q); op_b = ext(e2y_q); ctl.dest = DST_N0; ctl.sub = 1'b1; end
			5'd4: begin op_a = ext(e1x_q); op_b = ext(e2y_q); ctl.dest = DST_N2; ctl.clr = 1'b1; end
			5'd5: begin op_a = ext(e1y_q); op_b = ext(e2x_q); ctl.dest = DST_N2; ctl.sub = 1'b1; end
			5'd6: begin op_a = ext(wx_q);  op_b = ext(e2z_q); ctl.dest = DST_U;  ctl.clr = 1'b1; end
			5'd7: begin op_a = ext(wz_q);  op_b = ext(e2x_q); ctl.dest = DST_U;  ctl.sub = 1'b1; end
			5'd8: begin op_a = ext(e1x_q); op_b = ext(wz_q);  ctl.dest = DST_V;  ctl.clr = 1'b1; end
			5'd9: begin op_a = ext(e1z_q); op_b = ext(wx_q);  ctl.dest = DST_V;  ctl.sub = 1'b1; end
			5'd10: begin op_a = lo(n0_q); op_b = ext(wx_q); ctl.dest = DST_D; ctl.clr = 1'b1; end
			5'd11: begin op_a = hi(n0_q); op_b = ext(wx_q); ctl.dest = DST_D; ctl.hi = 1'b1; end
			5'd12: begin op_a = lo(n1_q); op_b = ext(wy_q); ctl.dest = DST_D; end
			5'd13: begin op_a = hi(n1_q); op_b = ext(wy_q); ctl.dest = DST_D; ctl.hi = 1'b1; end
			5'd14: begin op_a = lo(n2_q); op_b = ext(wz_q); ctl.dest = DST_D; end
			5'd15: begin op_a = hi(n2_q); op_b = ext(wz_q); ctl.dest = DST_D; ctl.hi = 1'b1; end
			default: ctl.vld = 1'b0;
		endcase
	end

	logic signed [PROD_W-1:0] prod_s1;
	mul_ctl_t                 ctl_s1;

	dfs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.op_a   (op_a),
		.op_b   (op_b),
		.ctl    (ctl),
		.prod_s1(prod_s1),
		.ctl_s1 (ctl_s1)
	);

	// signed product, optionally moved up by the split point and negated
	logic signed [DOT_W-1:0] term;

	always_comb begin
		term = {{(DOT_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		if (ctl_s1.hi) term = term <<< SPLIT;
		if (ctl_s1.sub) term = -term;
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.vld) begin
			case (ctl_s1.dest)
				DST_N0: n0_q <= (ctl_s1.clr ? '0 : n0_q) + term[NRM_W-1:0];
				DST_N1: n1_q <= (ctl_s1.clr ? '0 : n1_q) + term[NRM_W-1:0];
				DST_N2: n2_q <= (ctl_s1.clr ? '0 : n2_q) + term[NRM_W-1:0];
				DST_U:  u_q  <= (ctl_s1.clr ? '0 : u_q) + term[NRM_W-1:0];
				DST_V:  v_q  <= (ctl_s1.clr ? '0 : v_q) + term[NRM_W-1:0];
				DST_D:  d_q  <= (ctl_s1.clr ? '0 : d_q) + term;
				default: ;
			endcase
		end
	end

	// check: sign-normalize so the normal's y part is positive
	logic              n1_neg;
	logic [NRM_W-1:0]  nn;
	logic [DOT_W-1:0]  dd;
	logic [DOT_W-1:0]  lim31;
	logic              chk_rej;

	assign n1_neg  = n1_q[NRM_W-1];
	assign nn      = n1_neg ? NRM_W'(-n1_q) : n1_q;
	assign dd      = n1_neg ? DOT_W'(-d_q) : d_q;
	assign lim31   = DOT_W'({nn, 31'b0});
	// vertical or degenerate plane, hit above the origin, or drop of 2^31 and more
	assign chk_rej = (n1_q == '0) || dd[DOT_W-1] || (dd >= lim31);

	// restoring divider: drop = floor(dd / nn)
	logic [NRM_W-1:0]   nn_q;
	logic [DOT_W-1:0]   rem_q, dv_q;
	logic [QUO_W-1:0]   q_q;
	logic signed [NRM_W-1:0] uu_q, vv_q;
	logic               ge;

	assign ge = (rem_q >= dv_q);

	always_ff @(posedge clk) begin
		if (st_q == ST_CHK) begin
			nn_q  <= nn;
			rem_q <= dd;
			dv_q  <= DOT_W'({nn, 30'b0});
			q_q   <= '0;
			// barycentric denominator is -n1; flip u, v so it is positive
			uu_q  <= (n1_neg || n1_q == '0) ? u_q : -u_q;
			vv_q  <= (n1_neg || n1_q == '0) ? v_q : -v_q;
		end else if (st_q == ST_DIV) begin
			if (ge) rem_q <= rem_q - dv_q;
			q_q  <= {q_q[QUO_W-2:0], ge};
			dv_q <= dv_q >> 1;
		end
	end

	// finish: range, height with saturation, barycentric tolerance
	logic                    range_rej;
	logic signed [EDGE_W-1:0] y_full;
	logic signed [COORD_W-1:0] y;
	logic signed [BARY_W-1:0] su, sv, snn, tol, lhs, rhs;
	logic                    bary_rej;
	logic                    hit;
	logic                    better;
	logic                    can_emit;
	logic                    emit;
	logic signed [COORD_W-1:0] best_q;

	assign range_rej = (q_q > sdist_q) || ((q_q == sdist_q) && (rem_q != '0));
	assign y_full    = {ray_y_q[COORD_W-1], ray_y_q} - {2'b00, q_q};
	// the most negative height stands for anything below it
	assign y = (y_full < -(EDGE_W'(1) <<< (COORD_W-1))) ? {1'b1, {(COORD_W-1){1'b0}}}
		: y_full[COORD_W-1:0];

	assign su  = BARY_W'(uu_q) <<< FRAC_BITS;
	assign sv  = BARY_W'(vv_q) <<< FRAC_BITS;
	assign snn = BARY_W'({1'b0, nn_q});
	assign tol = (snn <<< 3) - snn;
	assign lhs = su + sv;
	assign rhs = (snn <<< FRAC_BITS) + tol;
	assign bary_rej = ((su + tol) < 0) || ((sv + tol) < 0) || (lhs > rhs);

	assign hit      = !rej_q && !range_rej && !bary_rej;
	assign better   = !seen_q || (y > best_q);
	assign can_emit = !out_vld_q || res_out.ready;
	// a last triangle hands its result over in the finish cycle
	assign emit     = (st_q == ST_FIN) && last_q && can_emit;

	logic [COORD_W-1:0] height_q;
	logic               found_q;

	// output register: loaded on emit, emptied when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (res_out.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			step_q    <= '0;
			cnt_q     <= '0;
			rej_q     <= 1'b0;
			seen_q    <= 1'b0;
			best_q    <= {1'b1, {(COORD_W-1){1'b0}}};
			height_q  <= '0;
			found_q   <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q   <= ST_MUL;
						step_q <= '0;
					end
				end
				ST_MUL: begin
					// last issue plus a drain step for the product register
					if (step_q == STEP_W'(NUM_STEPS)) st_q <= ST_CHK;
					step_q <= step_q + 1'b1;
				end
				ST_CHK: begin
					rej_q <= chk_rej;
					cnt_q <= CNT_W'(QUO_W - 1);
					st_q  <= chk_rej ? ST_FIN : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!last_q) begin
						if (hit && better) begin
							best_q <= y;
							seen_q <= 1'b1;
						end
						st_q <= ST_IDLE;
					end else if (can_emit) begin
						if (hit && better) begin
							height_q <= y;
							found_q  <= 1'b1;
						end else begin
							height_q <= seen_q ? best_q : '0;
							found_q  <= seen_q;
						end
						best_q <= {1'b1, {(COORD_W-1){1'b0}}};
						seen_q <= 1'b0;
						st_q   <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign res_out.valid        = out_vld_q;
	assign res_out.floor_height = height_q;
	assign res_out.hit_found    = found_q;

	// a result appears only from the finish of a last triangle
	a_emit_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(st_q == ST_FIN && last_q))
		else $error("result without last triangle");

	// the set state is cleared once a result is issued
	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> !seen_q)
		else $error("state not cleared after result");

	// divider works only on a nonzero divisor with a bounded remainder
	a_div_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV) |-> (nn_q != '0 && rem_q < DOT_W'({nn_q, 31'b0})))
		else $error("divider out of range");

endmodule

### dv/tb_downward_ray_floor_search.sv
module tb_downward_ray_floor_search;
	import dfs_pkg::*;

	// one triangle: nine coordinates a.xyz, b.xyz, c.xyz and the end-of-set flag
	typedef struct packed {
		logic [8:0][COORD_W-1:0] crd;
		logic                    last;
	} tri_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] height;
		logic               found;
	} floor_t;

	// wide enough for every exact product of the search
	typedef logic signed [159:0] wide_t;

	localparam int ONE       = 32'sh10000;
	localparam int LIMIT     = 3000000;
	localparam int SETTLE    = 120;
	localparam int LONG_HOLD = 400;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [1:0] wr_index;
	logic [COORD_W-1:0] wr_data;

	dfs_tri_if tri_if ();
	dfs_res_if res_if ();

	downward_ray_floor_search dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tri_in  (tri_if),
		.res_out (res_if),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data)
	);

	// predictor state and its copy of the registers
	logic signed [COORD_W-1:0] org_x, org_y, org_z;
	logic [SDIST_W-1:0]        max_drop;
	logic signed [COORD_W-1:0] best_h;
	bit                        hit_seen;

	tri_item_t triangle_q[$];
	floor_t    floor_q[$];
	tri_item_t on_bus;

	int  send_idle_pct;
	int  recv_stall_pct;
	bit  send_hold;
	int  hold_req;
	int  hold_seen;
	int  hold_cnt;
	int  errors;
	longint cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic wide_t wx(input logic [COORD_W-1:0] v);
		return wide_t'($signed(v));
	endfunction

	// exact ray/triangle test; hit height is the origin height minus floor(drop)
	function automatic bit ray_hits(input tri_item_t t, output logic signed [COORD_W-1:0] h);
		wide_t ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z, dx, dy, dz;
		wide_t n0, n1, n2, dot, q, y, cc, uu, vv, tol;
		ax  = wx(t.crd[0]); ay = wx(t.crd[1]); az = wx(t.crd[2]);
		e1x = wx(t.crd[3]) - ax; e1y = wx(t.crd[4]) - ay; e1z = wx(t.crd[5]) - az;
		e2x = wx(t.crd[6]) - ax; e2y = wx(t.crd[7]) - ay; e2z = wx(t.crd[8]) - az;
		dx  = wx(org_x) - ax; dy = wx(org_y) - ay; dz = wx(org_z) - az;
		h = '0;
		n1 = e1z * e2x - e1x * e2z;
		// degenerate and vertical planes both end here
		if (n1 == 0)
			return 0;
		n0 = e1y * e2z - e1z * e2y;
		n2 = e1x * e2y - e1y * e2x;
		dot = n0 * dx + n1 * dy + n2 * dz;
		if (n1 < 0) begin
			n1 = -n1;
			dot = -dot;
		end
		if (dot < 0)
			return 0;
		if ($signed({129'b0, max_drop}) * n1 < dot)
			return 0;
		q = dot / n1;
		y = wx(org_y) - q;
		if (y < -(wide_t'(1) <<< (COORD_W - 1)))
			y = -(wide_t'(1) <<< (COORD_W - 1));
		cc = e1x * e2z - e1z * e2x;
		uu = dx * e2z - dz * e2x;
		vv = e1x * dz - e1z * dx;
		if (cc < 0) begin
			cc = -cc; uu = -uu; vv = -vv;
		end
		tol = BARY_TOL * cc;
		if ((uu <<< FRAC_BITS) + tol < 0)
			return 0;
		if ((vv <<< FRAC_BITS) + tol < 0)
			return 0;
		if (((ONE + BARY_TOL) * cc) < ((uu + vv) <<< FRAC_BITS))
			return 0;
		h = y[COORD_W-1:0];
		return 1;
	endfunction

	// fold one accepted triangle into the running best floor
	function automatic void track_floor(input tri_item_t t);
		logic signed [COORD_W-1:0] h;
		floor_t r;
		if (ray_hits(t, h) && (!hit_seen || h > best_h)) begin
			best_h = h;
			hit_seen = 1;
		end
		if (t.last) begin
			r.height = hit_seen ? best_h : '0;
			r.found = hit_seen;
			floor_q.push_back(r);
			best_h = {1'b1, {(COORD_W-1){1'b0}}};
			hit_seen = 0;
		end
	endfunction

	// driver: predict on every accept, then offer the next item or idle
	always @(posedge clk) begin
		if (tri_if.valid && tri_if.ready)
			track_floor(on_bus);
		if (!tri_if.valid || tri_if.ready) begin
			if (triangle_q.size() > 0 && !send_hold
					&& $urandom_range(99) >= send_idle_pct) begin
				on_bus <= triangle_q[0];
				tri_if.vertex_a_x <= triangle_q[0].crd[0];
				tri_if.vertex_a_y <= triangle_q[0].crd[1];
				tri_if.vertex_a_z <= triangle_q[0].crd[2];
				tri_if.vertex_b_x <= triangle_q[0].crd[3];
				tri_if.vertex_b_y <= triangle_q[0].crd[4];
				tri_if.vertex_b_z <= triangle_q[0].crd[5];
				tri_if.vertex_c_x <= triangle_q[0].crd[6];
				tri_if.vertex_c_y <= triangle_q[0].crd[7];
				tri_if.vertex_c_z <= triangle_q[0].crd[8];
				tri_if.last_triangle <= triangle_q[0].last;
				tri_if.valid <= 1'b1;
				void'(triangle_q.pop_front());
			end else begin
				tri_if.valid <= 1'b0;
			end
		end
	end

	// monitor: check each accepted result, own stall and long hold-off counter
	always @(posedge clk) begin
		if (res_if.valid && res_if.ready) begin
			if (floor_q.size() == 0) begin
				$display("%0t unexpected result: height %h found %b", $time,
					res_if.floor_height, res_if.hit_found);
				errors++;
			end else begin
				if (res_if.floor_height !== floor_q[0].height) begin
					$display("%0t floor_height mismatch: expected %h actual %h", $time,
						floor_q[0].height, res_if.floor_height);
					errors++;
				end
				if (res_if.hit_found !== floor_q[0].found) begin
					$display("%0t hit_found mismatch: expected %b actual %b", $time,
						floor_q[0].found, res_if.hit_found);
					errors++;
				end
				void'(floor_q.pop_front());
			end
		end
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_cnt <= LONG_HOLD;
			res_if.ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[downward_ray_floor_search] ERROR");
			$finish;
		end
	end

	function automatic logic [COORD_W-1:0] clamp(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[COORD_W-1:0];
	endfunction

	function automatic tri_item_t flat_tri(input longint x0, x1, z0, z1, y, input bit last);
		tri_item_t t;
		t.crd = {clamp(z0), clamp(y), clamp(x0), clamp(z0), clamp(y), clamp(x1),
			clamp(z1), clamp(y), clamp(x0)};
		// the concatenation above fills crd[8] first; reorder into a, b, c
		t.crd[0] = clamp(x0); t.crd[1] = clamp(y); t.crd[2] = clamp(z0);
		t.crd[3] = clamp(x1); t.crd[4] = clamp(y); t.crd[5] = clamp(z0);
		t.crd[6] = clamp(x0); t.crd[7] = clamp(y); t.crd[8] = clamp(z1);
		t.last = last;
		return t;
	endfunction

	// random item: mostly tilted triangles around the ray below the origin, rest noise
	function automatic tri_item_t rand_tri();
		tri_item_t t;
		longint r, rx, ry, rz, drop;
		int sel;
		sel = $urandom_range(99);
		t.last = ($urandom_range(3) == 0);
		if (sel < 12) begin
			for (int i = 0; i < 9; i++)
				t.crd[i] = $urandom();
			return t;
		end
		r = longint'(1) << $urandom_range(6, 24);
		rx = longint'(org_x); ry = longint'(org_y); rz = longint'(org_z);
		drop = longint'($urandom_range(0, 32'h7fffffff)) >> $urandom_range(0, 20);
		if (sel < 20)
			drop = -drop;
		t.crd[0] = clamp(rx - r - $urandom_range(0, 255));
		t.crd[2] = clamp(rz - r + $urandom_range(0, 255) - 128);
		t.crd[3] = clamp(rx + r + $urandom_range(0, 255));
		t.crd[5] = clamp(rz - r - $urandom_range(0, 255));
		t.crd[6] = clamp(rx + $urandom_range(0, 511) - 256);
		t.crd[8] = clamp(rz + r + $urandom_range(0, 255));
		t.crd[1] = clamp(ry - drop + $urandom_range(0, 4095) - 2048);
		t.crd[4] = clamp(ry - drop + $urandom_range(0, 4095) - 2048);
		t.crd[7] = clamp(ry - drop + $urandom_range(0, 4095) - 2048);
		if (sel < 28)
			t.crd[6] = clamp(rx + 3 * r);
		return t;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [COORD_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_RAY_X: org_x = val;
			REG_RAY_Y: org_y = val;
			REG_RAY_Z: org_z = val;
			REG_SDIST: max_drop = val[SDIST_W-1:0];
			default: ;
		endcase
	endtask

	// wait until the queue is sent and every result is back, then let the block settle
	task automatic drain();
		while (triangle_q.size() > 0 || tri_if.valid || floor_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_idling(input int ph);
		case (ph % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
			default: begin send_idle_pct = 25; recv_stall_pct = 25; end
		endcase
	endtask

	task automatic fill_random(input int n);
		tri_item_t t;
		for (int i = 0; i < n; i++) begin
			t = rand_tri();
			if (i == n - 1)
				t.last = 1;
			triangle_q.push_back(t);
		end
	endtask

	initial begin
		tri_item_t t;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_RAY_X;
		wr_data = '0;
		tri_if.valid = 1'b0;
		tri_if.vertex_a_x = '0; tri_if.vertex_a_y = '0; tri_if.vertex_a_z = '0;
		tri_if.vertex_b_x = '0; tri_if.vertex_b_y = '0; tri_if.vertex_b_z = '0;
		tri_if.vertex_c_x = '0; tri_if.vertex_c_y = '0; tri_if.vertex_c_z = '0;
		tri_if.last_triangle = 1'b0;
		res_if.ready = 1'b0;
		on_bus = '0;
		org_x = '0; org_y = '0; org_z = '0;
		max_drop = SDIST_RESET;
		best_h = {1'b1, {(COORD_W-1){1'b0}}};
		hit_seen = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		send_hold = 0;
		hold_req = 0; hold_seen = 0; hold_cnt = 0;
		errors = 0;
		cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part with the reset registers: ray at the origin, reach 4096
		triangle_q.push_back(flat_tri(-ONE, ONE, -ONE, ONE, -ONE, 0));
		triangle_q.push_back(flat_tri(-ONE, ONE, -ONE, ONE, -ONE / 2, 1));
		// degenerate triangle, then vertical plane, each closing a set
		t = '0; t.last = 1; triangle_q.push_back(t);
		t = flat_tri(0, 0, -ONE, ONE, 0, 1); t.crd[4] = -ONE; triangle_q.push_back(t);
		// above the origin, below the reach, off to the side
		triangle_q.push_back(flat_tri(-ONE, ONE, -ONE, ONE, ONE, 1));
		triangle_q.push_back(flat_tri(-ONE, ONE, -ONE, ONE, -5000 * ONE, 1));
		triangle_q.push_back(flat_tri(2 * ONE, 3 * ONE, -ONE, ONE, -ONE, 1));
		// barycentric tolerance: outside by exactly 7 lsb passes, by 8 fails
		triangle_q.push_back(flat_tri(7, 7 + ONE, 7, 7 + ONE, -2 * ONE, 1));
		triangle_q.push_back(flat_tri(8, 8 + ONE, -ONE, ONE, -2 * ONE, 1));
		triangle_q.push_back(flat_tri(-ONE, 0, -ONE, 0, -3, 1));
		// tie: equal heights, then a lower one, set ends with no hit on last
		triangle_q.push_back(flat_tri(-ONE, ONE, -ONE, ONE, -3 * ONE, 0));
		triangle_q.push_back(flat_tri(-2 * ONE, ONE, -ONE, ONE, -3 * ONE, 0));
		triangle_q.push_back(flat_tri(-ONE, ONE, -ONE, ONE, -4 * ONE, 0));
		triangle_q.push_back(flat_tri(5 * ONE, 6 * ONE, -ONE, ONE, -ONE, 1));
		// hit right at the origin, zero drop
		triangle_q.push_back(flat_tri(-ONE, ONE, -ONE, ONE, 0, 1));
		// extreme coordinates
		t.crd = {9{32'h80000000}}; t.crd[3] = 32'h7fffffff; t.crd[8] = 32'h7fffffff;
		t.last = 1; triangle_q.push_back(t);
		t.crd = {9{32'h7fffffff}}; t.crd[0] = 32'h80000000; t.crd[5] = 32'h80000000;
		t.crd[7] = 32'h80000000; t.last = 1; triangle_q.push_back(t);
		t.crd = {9{32'hffffffff}}; t.crd[4] = 32'h0; t.last = 1; triangle_q.push_back(t);
		drain();

		// random phases over several register settings, each idling mode in turn
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_RAY_X, 32'h0003_8000);
					write_reg(REG_RAY_Y, 32'h0010_0000);
					write_reg(REG_RAY_Z, 32'hfffd_0000);
					write_reg(REG_SDIST, 32'h0100_0000);
				end
				1: write_reg(REG_SDIST, 32'h7fffffff);
				2: begin
					write_reg(REG_RAY_X, 32'h7fffffff);
					write_reg(REG_RAY_Y, 32'h7fffffff);
					write_reg(REG_RAY_Z, 32'h7fffffff);
				end
				3: begin
					write_reg(REG_RAY_X, 32'h80000000);
					write_reg(REG_RAY_Y, 32'h80000000);
					write_reg(REG_RAY_Z, 32'h80000000);
				end
				4: begin
					write_reg(REG_RAY_X, 32'h0);
					write_reg(REG_RAY_Y, 32'h0);
					write_reg(REG_RAY_Z, 32'h0);
					write_reg(REG_SDIST, 32'h0);
				end
				default: begin
					write_reg(REG_RAY_X, $urandom());
					write_reg(REG_RAY_Y, $urandom());
					write_reg(REG_RAY_Z, $urandom());
					write_reg(REG_SDIST, COORD_W'($urandom_range(0, 32'h7fffffff)));
				end
			endcase
			set_idling(ph);
			if (ph == 2) begin
				// long receiver hold-off while triangles keep coming
				fill_random(60);
				hold_req <= hold_req + 1;
				drain();
			end
			fill_random(110);
			// sender pauses until the block has returned everything
			while (triangle_q.size() > 0 || tri_if.valid) @(posedge clk);
			send_hold = 1;
			while (floor_q.size() > 0) @(posedge clk);
			send_hold = 0;
			fill_random(110);
			drain();
		end

		if (errors == 0)
			$display("[downward_ray_floor_search] OK");
		else
			$display("[downward_ray_floor_search] ERROR");
		$finish;
	end

endmodule

### files.f
hdl/dfs_pkg.sv
hdl/dfs_ifs.sv
hdl/dfs_mul.sv
hdl/downward_ray_floor_search.sv
dv/tb_downward_ray_floor_search.sv
